[hw/rtl/lcabl_pkg.sv]
// Shared types, widths and helpers for the lowest common ancestor engine.
package lcabl_pkg;

	// Node ids and depths on the ports are ten bits wide
	localparam int ID_W  = 10;
	// Bits of a floor log2 over an id-wide value
	localparam int LOG_W = $clog2(ID_W);
	localparam int KIND_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD  = 2'd0,
		KIND_BUILD = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BUILD,
		ST_DRAIN,
		ST_DEPTH,
		ST_ORDER,
		ST_LIFT,
		ST_LIFT_W,
		ST_BOTH,
		ST_BOTH_W,
		ST_FINAL,
		ST_FINAL_W,
		ST_DONE
	} state_t;

	// Position of the highest set bit; zero for zero and one
	function automatic logic [LOG_W-1:0] floor_log2(input logic [ID_W-1:0] x);
		logic [LOG_W-1:0] r;
		r = '0;
		for (int j = 0; j < ID_W; j++) begin
			if (x[j]) r = LOG_W'(j);
		end
		return r;
	endfunction

endpackage

[hw/rtl/lca_binary_lifting.sv]
// Lowest common ancestor engine: node tables, jump table build and lifting query.
// Load writes the node tables as it is taken. Build: level by level over every slot, one table entry a cycle.
// Query: depth read, order, then a read and an update turn on the jump memory per depth lift step and
// per lift level for both nodes, then a final parent read; equal or bad ids go straight to done.
// One item is in work at a time; the result register frees the input while a result waits.
// Reset clears control and sets node_count to 1023; memories are not cleared, parent/depth slot 0 reads zero.
module lca_binary_lifting #(
	parameter int NODE_SLOTS  = 1024,
	parameter int LIFT_LEVELS = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lcabl_pkg::ID_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lcabl_pkg::KIND_W-1:0]     kind,
	input  logic [lcabl_pkg::ID_W-1:0]       node_a,
	input  logic [lcabl_pkg::ID_W-1:0]       node_b,
	input  logic [lcabl_pkg::ID_W-1:0]       node_depth,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lcabl_pkg::ID_W-1:0]       ancestor,
	output logic                             bad_node
);
	import lcabl_pkg::*;

	localparam int AW     = $clog2(NODE_SLOTS);
	localparam int LW     = $clog2(LIFT_LEVELS);
	localparam int JDEPTH = NODE_SLOTS * LIFT_LEVELS;
	localparam int JAW    = $clog2(JDEPTH);
	localparam int PDW    = 2 * ID_W;

	// Clamp an id to a table slot: ids past the table act as slot 0
	function automatic logic [ID_W-1:0] slot_id(input logic [ID_W-1:0] id);
		logic [31:0] w;
		w = 32'(id);
		return (w < NODE_SLOTS) ? id : '0;
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [ID_W-1:0] id);
		logic [31:0] w;
		w = 32'(slot_id(id));
		return w[AW-1:0];
	endfunction

	function automatic logic [JAW-1:0] jaddr(input logic [LW-1:0] lvl, input logic [AW-1:0] s);
		return JAW'(lvl) * JAW'(NODE_SLOTS) + JAW'(s);
	endfunction

	state_t state_q, state_d;

	logic [ID_W-1:0] node_count_q;

	// Parent/depth memory: one write, two registered reads
	logic [PDW-1:0]  pd_mem [NODE_SLOTS];
	logic            pd_we;
	logic [AW-1:0]   pd_waddr;
	logic [PDW-1:0]  pd_wdata;
	logic [AW-1:0]   pd_raddr_a, pd_raddr_b;
	logic [PDW-1:0]  pd_rd_a_q, pd_rd_b_q;

	// Jump memory: one write, two registered reads
	logic [ID_W-1:0] jmem [JDEPTH];
	logic            jw_en;
	logic [JAW-1:0]  jw_addr;
	logic [ID_W-1:0] jw_data;
	logic [JAW-1:0]  ja_addr, jb_addr;
	logic [ID_W-1:0] jrd_a_q, jrd_b_q;

	// Build sweep and its pipeline
	logic [AW-1:0]   i_q;
	logic [LW-1:0]   lvl_q;
	logic            v_s1, v_s2;
	logic [AW-1:0]   idx_s1, idx_s2;
	logic            i_last;

	// Query registers
	logic [ID_W-1:0] u_q, v_q, diff_q, anc_q;
	logic            bad_q;
	logic [LOG_W-1:0] fl;
	logic [LW-1:0]   lift_p;
	logic [ID_W-1:0] ja_id, jb_id;
	logic [ID_W-1:0] da, db;

	// Result register
	logic            out_valid_q;
	logic [ID_W-1:0] ancestor_q;
	logic            bad_node_q;
	logic            out_free;
	logic            in_take;
	logic            a_ok, b_ok;

	function automatic logic id_ok(input logic [ID_W-1:0] id, input logic [ID_W-1:0] cnt);
		return (id != '0) && (id <= cnt) && (32'(id) < NODE_SLOTS);
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign ancestor  = ancestor_q;
	assign bad_node  = bad_node_q;

	assign a_ok   = id_ok(node_a, node_count_q);
	assign b_ok   = id_ok(node_b, node_count_q);
	assign i_last = (32'(i_q) == NODE_SLOTS - 1);
	assign fl     = floor_log2(diff_q);
	assign lift_p = (int'(fl) > LIFT_LEVELS - 1) ? LW'(LIFT_LEVELS - 1) : LW'(fl);
	assign ja_id  = slot_id(jrd_a_q);
	assign jb_id  = slot_id(jrd_b_q);
	assign da     = pd_rd_a_q[ID_W-1:0];
	assign db     = pd_rd_b_q[ID_W-1:0];

	// Hold the node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= ID_W'(1023);
		end else if (cfg_we) begin
			node_count_q <= cfg_data;
		end
	end

	// Advance the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control
	always_comb begin
		state_d    = state_q;
		pd_we      = 1'b0;
		pd_waddr   = to_addr(node_a);
		pd_wdata   = {node_b, node_depth};
		pd_raddr_a = to_addr(u_q);
		pd_raddr_b = to_addr(v_q);
		ja_addr    = jaddr(lvl_q, to_addr(u_q));
		jb_addr    = jaddr(lvl_q, to_addr(v_q));
		jw_en      = 1'b0;
		jw_addr    = jaddr(lvl_q, idx_s2);
		jw_data    = jrd_b_q;

		// Drain the build pipeline regardless of state
		if (v_s1) begin
			if (lvl_q == '0) begin
				jw_en   = 1'b1;
				jw_addr = jaddr('0, idx_s1);
				jw_data = slot_id(pd_rd_a_q[PDW-1:ID_W]);
			end else begin
				jb_addr = jaddr(lvl_q - LW'(1), to_addr(jrd_a_q));
			end
		end
		if (v_s2) begin
			jw_en   = 1'b1;
			jw_addr = jaddr(lvl_q, idx_s2);
			jw_data = jrd_b_q;
		end

		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					case (kind)
						KIND_LOAD: begin
							pd_we = a_ok;
						end
						KIND_BUILD: begin
							state_d = ST_BUILD;
						end
						KIND_QUERY: begin
							if (!a_ok || !b_ok || (node_a == node_b)) state_d = ST_DONE;
							else state_d = ST_DEPTH;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_BUILD: begin
				if (lvl_q == '0) pd_raddr_a = i_q;
				else ja_addr = jaddr(lvl_q - LW'(1), i_q);
				if (i_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					if (32'(lvl_q) == LIFT_LEVELS - 1) state_d = ST_IDLE;
					else state_d = ST_BUILD;
				end
			end
			ST_DEPTH: begin
				state_d = ST_ORDER;
			end
			ST_ORDER: begin
				state_d = ST_LIFT;
			end
			ST_LIFT: begin
				ja_addr = jaddr(lift_p, to_addr(u_q));
				if (diff_q != '0) state_d = ST_LIFT_W;
				else if (u_q == v_q) state_d = ST_DONE;
				else state_d = ST_BOTH;
			end
			ST_LIFT_W: begin
				state_d = ST_LIFT;
			end
			ST_BOTH: begin
				state_d = ST_BOTH_W;
			end
			ST_BOTH_W: begin
				if (lvl_q == '0) state_d = ST_FINAL;
				else state_d = ST_BOTH;
			end
			ST_FINAL: begin
				ja_addr = jaddr('0, to_addr(u_q));
				state_d = ST_FINAL_W;
			end
			ST_FINAL_W: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Parent/depth memory; slot 0 always reads as zero
	always_ff @(posedge clk) begin
		if (pd_we) pd_mem[pd_waddr] <= pd_wdata;
		pd_rd_a_q <= (pd_raddr_a == '0) ? '0 : pd_mem[pd_raddr_a];
		pd_rd_b_q <= (pd_raddr_b == '0) ? '0 : pd_mem[pd_raddr_b];
	end

	// Jump memory
	always_ff @(posedge clk) begin
		if (jw_en) jmem[jw_addr] <= jw_data;
		jrd_a_q <= jmem[ja_addr];
		jrd_b_q <= jmem[jb_addr];
	end

	// Build pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_BUILD);
			v_s2 <= v_s1 && (lvl_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= i_q;
		idx_s2 <= idx_s1;
	end

	// Sweep counters and query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				i_q   <= '0;
				lvl_q <= '0;
				u_q   <= node_a;
				v_q   <= node_b;
				bad_q <= !a_ok || !b_ok;
				anc_q <= (!a_ok || !b_ok) ? '0 : node_a;
			end
			ST_BUILD: begin
				i_q <= i_q + AW'(1);
			end
			ST_DRAIN: begin
				i_q <= '0;
				if (!v_s1 && !v_s2) lvl_q <= lvl_q + LW'(1);
			end
			ST_ORDER: begin
				// Put the deeper node in u
				if (da < db) begin
					u_q    <= v_q;
					v_q    <= u_q;
					diff_q <= db - da;
				end else begin
					diff_q <= da - db;
				end
			end
			ST_LIFT: begin
				lvl_q <= LW'(LIFT_LEVELS - 1);
				anc_q <= u_q;
			end
			ST_LIFT_W: begin
				u_q    <= ja_id;
				diff_q <= diff_q - (ID_W'(1) << lift_p);
			end
			ST_BOTH_W: begin
				if (ja_id != jb_id) begin
					u_q <= ja_id;
					v_q <= jb_id;
				end
				if (lvl_q != '0) lvl_q <= lvl_q - LW'(1);
			end
			ST_FINAL_W: begin
				anc_q <= ja_id;
			end
			default: begin
				i_q <= i_q;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			ancestor_q <= anc_q;
			bad_node_q <= bad_q;
		end
	end

`ifndef ASSERT_OFF
	a_s2_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_BUILD || state_q == ST_DRAIN))
		else $error("build second stage active outside build");

	a_s2_not_level0: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (lvl_q != '0))
		else $error("second build stage active on level zero");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid)
		else $error("finished query did not reach the result register");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_node) |-> (ancestor == '0))
		else $error("bad query carries a nonzero ancestor");

	a_lift_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIFT_W) |=> (diff_q < $past(diff_q)))
		else $error("depth lift did not reduce the remaining distance");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the binary lifting lowest common ancestor engine.
module tb_top;
	import lcabl_pkg::*;

	localparam int SLOTS  = 1024;
	localparam int LEVELS = 11;
	// Kind 3 has no meaning for the block and must be dropped
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam bit ROW_ITEM      = 1'b0;
	localparam bit ROW_SET_COUNT = 1'b1;
	localparam int ITEM_GOAL  = 1850;
	localparam int BUILD_WAIT = LEVELS * (SLOTS + 3) + 200;
	localparam int SHORT_WAIT = 64;
	localparam int RUN_LIMIT  = 4 * 6_000_000;

	typedef logic [ID_W-1:0] id_t;

	typedef struct packed {
		id_t  anc;
		logic bad;
	} lca_res_t;

	typedef struct packed {
		bit                op;
		logic [KIND_W-1:0] kind;
		id_t               a;
		id_t               b;
		id_t               d;
		bit                typed;
		id_t               anc;
		logic              bad;
	} plan_row_t;

	// Directed beats: error ids and equal nodes before any build, then tree queries
	localparam int PLAN_ROWS = 24;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_ITEM, KIND_QUERY, 10'd0, 10'd5, 10'd0, 1'b1, 10'd0, 1'b1},
		'{ROW_ITEM, KIND_QUERY, 10'd5, 10'd0, 10'd0, 1'b1, 10'd0, 1'b1},
		'{ROW_ITEM, KIND_QUERY, 10'd0, 10'd0, 10'd0, 1'b1, 10'd0, 1'b1},
		'{ROW_ITEM, KIND_QUERY, 10'd1023, 10'd1023, 10'd1022, 1'b1, 10'd1023, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1, 10'd1, 10'd0, 1'b1, 10'd1, 1'b0},
		'{ROW_ITEM, KIND_SPARE, 10'd1023, 10'd1023, 10'd1023, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_LOAD, 10'd0, 10'd1023, 10'd1022, 1'b0, 10'd0, 1'b0},
		'{ROW_SET_COUNT, KIND_LOAD, 10'd1, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1, 10'd1, 10'd0, 1'b1, 10'd1, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1, 10'd2, 10'd0, 1'b1, 10'd0, 1'b1},
		'{ROW_ITEM, KIND_QUERY, 10'd1023, 10'd1, 10'd0, 1'b1, 10'd0, 1'b1},
		'{ROW_ITEM, KIND_LOAD, 10'd2, 10'd1, 10'd1, 1'b0, 10'd0, 1'b0},
		'{ROW_SET_COUNT, KIND_LOAD, 10'd1023, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_BUILD, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1023, 10'd1, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1, 10'd1023, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd512, 10'd341, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1000, 10'd999, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_LOAD, 10'd1023, 10'd0, 10'd1022, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1023, 10'd512, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_LOAD, 10'd1023, 10'd1, 10'd1, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_BUILD, 10'd1023, 10'd1023, 10'd1022, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1023, 10'd1, 10'd0, 1'b0, 10'd0, 1'b0},
		'{ROW_ITEM, KIND_QUERY, 10'd1022, 10'd1023, 10'd0, 1'b0, 10'd0, 1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	id_t               cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [KIND_W-1:0] kind = '0;
	id_t               node_a = '0;
	id_t               node_b = '0;
	id_t               node_depth = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	id_t               ancestor;
	logic              bad_node;

	// Shadow copy of the node tables, jump table and node_count
	id_t up_par [SLOTS];
	id_t up_dep [SLOTS];
	id_t hop [SLOTS][LEVELS];
	id_t live_count = 10'd1023;

	lca_res_t pending_lca [$];
	lca_res_t seen_want;

	int unsigned mismatches = 0;
	int unsigned n_checked = 0;
	int unsigned n_loads = 0;
	int unsigned n_builds = 0;
	int unsigned n_queries = 0;
	int unsigned n_bad = 0;
	int unsigned n_ignored = 0;
	int unsigned work_items = 0;
	int unsigned n_phases = 0;
	bit          last_was_build = 1'b0;
	bit          gap_on = 1'b1;
	int unsigned burst_left = 0;
	logic [15:0] stall_tick = '0;
	logic [1:0]  stall_mode = '0;

	lca_binary_lifting #(
		.NODE_SLOTS (SLOTS),
		.LIFT_LEVELS(LEVELS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.node_a    (node_a),
		.node_b    (node_b),
		.node_depth(node_depth),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ancestor  (ancestor),
		.bad_node  (bad_node)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			up_par[i] = '0;
			up_dep[i] = '0;
			for (int k = 0; k < LEVELS; k++) hop[i][k] = '0;
		end
	end

	function automatic bit id_ok(input id_t id);
		return id != '0 && id <= live_count;
	endfunction

	// Fill level 0 from the parents, then each level from the one below
	function automatic void rebuild_hops();
		for (int i = 0; i < SLOTS; i++) hop[i][0] = up_par[i];
		for (int k = 1; k < LEVELS; k++) begin
			for (int i = 0; i < SLOTS; i++) hop[i][k] = hop[hop[i][k-1]][k-1];
		end
	endfunction

	// Lift the deeper node to the other's depth, then both together from the top level
	function automatic id_t meet_point(input id_t a, input id_t b);
		id_t u, v, t;
		int unsigned gap, lift;
		u = a;
		v = b;
		if (u == v) return u;
		if (up_dep[u] < up_dep[v]) begin
			t = u;
			u = v;
			v = t;
		end
		gap = up_dep[u] - up_dep[v];
		while (gap != 0) begin
			lift = $clog2(gap + 1) - 1;
			if (lift >= LEVELS) lift = LEVELS - 1;
			gap -= 1 << lift;
			u = hop[u][lift];
		end
		if (u == v) return u;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if (hop[u][k] != hop[v][k]) begin
				u = hop[u][k];
				v = hop[v][k];
			end
		end
		return hop[u][0];
	endfunction

	// Update the shadow state, queue the expected result, then send one beat
	task automatic feed(input logic [KIND_W-1:0] k, input id_t a, input id_t b, input id_t d,
			input bit typed = 1'b0, input lca_res_t typed_res = '0);
		lca_res_t got;
		case (k)
			KIND_LOAD: begin
				if (id_ok(a)) begin
					up_par[a] = b;
					up_dep[a] = d;
					n_loads++;
					work_items++;
				end else begin
					n_ignored++;
				end
			end
			KIND_BUILD: begin
				rebuild_hops();
				n_builds++;
				work_items++;
			end
			KIND_QUERY: begin
				if (typed) got = typed_res;
				else if (!id_ok(a) || !id_ok(b)) got = '{anc: '0, bad: 1'b1};
				else got = '{anc: meet_point(a, b), bad: 1'b0};
				if (got.bad) n_bad++;
				pending_lca = {pending_lca, got};
				n_queries++;
				work_items++;
			end
			default: n_ignored++;
		endcase
		last_was_build = (k == KIND_BUILD);

		// Hold off between bursts
		if (gap_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left != 0) burst_left--;
		in_valid   <= 1'b1;
		kind       <= k;
		node_a     <= a;
		node_b     <= b;
		node_depth <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid, wait for every result, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_lca.size() != 0) @(posedge clk);
		repeat (last_was_build ? BUILD_WAIT : SHORT_WAIT) @(posedge clk);
	endtask

	task automatic write_count(input id_t v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		live_count = v;
	endtask

	// Malformed or meaningless beats
	task automatic stray_item();
		id_t a;
		case ($urandom_range(0, 7))
			0, 1: feed(KIND_SPARE, id_t'($urandom_range(0, 1023)),
					id_t'($urandom_range(0, 1023)), id_t'($urandom_range(0, 1023)));
			2, 3: begin
				if (live_count == 10'd1023 || $urandom_range(0, 1) == 0) a = '0;
				else a = id_t'($urandom_range(live_count + 1, 1023));
				feed(KIND_LOAD, a, id_t'($urandom_range(0, 1023)),
					id_t'($urandom_range(0, 1022)));
			end
			4, 5, 6: feed(KIND_QUERY, id_t'($urandom_range(0, 1023)),
					id_t'($urandom_range(0, 1023)), id_t'($urandom_range(0, 1022)));
			default: feed(KIND_LOAD, id_t'($urandom_range(1, live_count)),
					id_t'($urandom_range(0, 1023)), id_t'($urandom_range(0, 1022)));
		endcase
	endtask

	// Load a fresh random forest over ids 1..span, biased toward long chains
	task automatic plant_tree(input int unsigned span, input bit noisy);
		id_t perm [SLOTS];
		id_t t, up, lvl;
		int unsigned j;
		for (int i = 0; i < span; i++) perm[i] = id_t'(i + 1);
		for (int i = span - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < span; i++) begin
			if (noisy && $urandom_range(0, 11) == 0) stray_item();
			if (i == 0 || $urandom_range(0, 15) == 0) up = '0;
			else if ($urandom_range(0, 3) != 0) up = perm[i-1];
			else up = perm[$urandom_range(0, i - 1)];
			if (up_dep[up] >= 10'd1022) up = '0;
			lvl = (up == '0) ? id_t'(0) : up_dep[up] + 1'b1;
			feed(KIND_LOAD, perm[i], up, lvl);
		end
	endtask

	// Move leaves under new parents; the table stays stale until the next build
	task automatic regraft(input int unsigned span, input int unsigned n);
		id_t x, p;
		bit leaf;
		for (int m = 0; m < n; m++) begin
			leaf = 1'b0;
			for (int tries = 0; tries < 20 && !leaf; tries++) begin
				x = id_t'($urandom_range(1, span));
				leaf = 1'b1;
				for (int y = 1; y <= span; y++) if (up_par[y] == x) leaf = 1'b0;
			end
			p = id_t'($urandom_range(1, span));
			if (leaf && p != x && up_dep[p] < 10'd1022)
				feed(KIND_LOAD, x, p, up_dep[p] + 1'b1);
		end
	endtask

	// Query mostly valid pairs, with some equal pairs and some bad ids
	task automatic ask_many(input int unsigned span, input int unsigned n);
		id_t a, b, t;
		int unsigned r;
		for (int m = 0; m < n; m++) begin
			r = $urandom_range(0, 19);
			if (r == 0) stray_item();
			a = id_t'($urandom_range(1, span));
			b = (r < 3) ? a : id_t'($urandom_range(1, span));
			if (r >= 3 && r < 6) begin
				b = (span == 1023 || r == 3) ? id_t'(0) : id_t'($urandom_range(span + 1, 1023));
				if ($urandom_range(0, 1) == 1) begin
					t = a;
					a = b;
					b = t;
				end
			end
			feed(KIND_QUERY, a, b, id_t'($urandom_range(0, 1022)));
		end
	endtask

	// Receiver stall pattern, picked anew at random each time the low byte of stall_tick is zero
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (stall_tick[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= stall_tick[2];
		endcase
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lca.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: unexpected result beat, ancestor %0d bad_node %0b",
						$time, ancestor, bad_node);
			end else begin
				seen_want = pending_lca.pop_front();
				n_checked++;
				if (ancestor !== seen_want.anc) begin
					mismatches++;
					if (mismatches <= 40)
						$display("%0t: ancestor expected %0d actual %0d",
							$time, seen_want.anc, ancestor);
				end
				if (bad_node !== seen_want.bad) begin
					mismatches++;
					if (mismatches <= 40)
						$display("%0t: bad_node expected %0b actual %0b",
							$time, seen_want.bad, bad_node);
				end
			end
		end
	end

	initial begin
		int unsigned span;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Define every node slot before the first build reads them all
		plant_tree(1023, 1'b0);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (PLAN[r].op == ROW_SET_COUNT) begin
				settle();
				write_count(PLAN[r].a);
			end else begin
				feed(PLAN[r].kind, PLAN[r].a, PLAN[r].b, PLAN[r].d, PLAN[r].typed,
					'{anc: PLAN[r].anc, bad: PLAN[r].bad});
			end
		end

		// Random phases: new count, fresh tree, build, queries, stale-table queries
		while (work_items < ITEM_GOAL) begin
			if (n_phases == 0) span = 1023;
			else if (n_phases == 1) span = 1;
			else if (n_phases % 5 == 0) span = $urandom_range(65, 200);
			else span = $urandom_range(2, 48);
			gap_on = (n_phases % 3 != 2);
			if (id_t'(span) != live_count) begin
				settle();
				write_count(id_t'(span));
			end
			if (n_phases != 0) plant_tree(span, 1'b1);
			feed(KIND_BUILD, '0, '0, '0);
			ask_many(span, $urandom_range(12, 40));
			if ($urandom_range(0, 2) == 0) settle();
			if (span >= 2 && $urandom_range(0, 1) == 1) begin
				regraft(span, $urandom_range(1, 6));
				ask_many(span, $urandom_range(4, 12));
			end
			n_phases++;
		end

		settle();
		$display("covered %0d loads, %0d builds, %0d queries (%0d with bad ids), %0d dropped beats",
			n_loads, n_builds, n_queries, n_bad, n_ignored);
		$display("checked %0d results over %0d random tree phases", n_checked, n_phases);
		if (mismatches == 0 && pending_lca.size() == 0) begin
			$display("lca_binary_lifting test passed");
		end else begin
			$display("lca_binary_lifting test failed");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("lca_binary_lifting test failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lcabl_pkg.sv
hw/rtl/lca_binary_lifting.sv
dv/tb_top.sv
